[hw/rtl/orlog_pkg.sv]
// ----------------------------------------------------------------------------
// orlog_pkg
// Shared types and codes for the overwrite-oldest ring event log.
// ----------------------------------------------------------------------------
`default_nettype none

package orlog_pkg;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // number of valid codes per event field
  localparam logic [3:0] NUM_CATEGORY = 4'd3;
  localparam logic [3:0] NUM_ACTION   = 4'd12;
  localparam logic [3:0] NUM_OUTCOME  = 4'd4;

  typedef struct packed {
    logic       present;
    logic [1:0] outcome;
    logic [3:0] action;
    logic [1:0] category;
  } tags_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] time_ms;
    logic [31:0] value;
    tags_t       tags;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/orlog_mem.sv]
// ----------------------------------------------------------------------------
// orlog_mem
// Single-port entry store with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module orlog_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic               clk,
  input  wire orlog_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]      addr,
  input  wire orlog_pkg::entry_t  wdata,
  output orlog_pkg::entry_t       rdata
);
  import orlog_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/orlog_ctrl.sv]
// ----------------------------------------------------------------------------
// orlog_ctrl
// Ring pointers, counters, command sequencing and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module orlog_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int FW       = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [63:0]         in_event_time_ms,
  input  wire logic [3:0]          in_event_category,
  input  wire logic [3:0]          in_event_action,
  input  wire logic [3:0]          in_event_outcome,
  input  wire logic                in_value_present,
  input  wire logic [31:0]         in_value_bits,
  input  wire logic [5:0]          in_read_index,
  output orlog_pkg::mem_ctl_t      mem_ctl,
  output logic [AW-1:0]            mem_addr,
  output orlog_pkg::entry_t        mem_wdata,
  input  wire orlog_pkg::entry_t   mem_rdata,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic [31:0]              out_seq_number,
  output logic [63:0]              out_time_ms,
  output logic [31:0]              out_value_bits,
  output logic [1:0]               out_category,
  output logic [3:0]               out_action,
  output logic [1:0]               out_outcome,
  output logic                     out_value_present,
  output logic [6:0]               out_entry_count,
  output logic [31:0]              out_drop_count,
  output logic [31:0]              out_last_seq
);
  import orlog_pkg::*;

  localparam int SW = ((AW > 6) ? AW : 6) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [31:0]    seq_r, seq_nxt;
  logic [31:0]    drops_r, drops_nxt;
  logic [1:0]     op_r;
  logic           ok_r;
  logic [31:0]    seqnum_r;
  logic           out_valid_r;
  logic           out_ok_r;
  logic [31:0]    out_seq_number_r;
  entry_t         out_entry_r;

  logic           accept;
  logic           evt_good;
  logic           not_full;
  logic           read_hit;
  logic [AW-1:0]  append_slot;
  logic [AW-1:0]  read_slot;
  logic           ok_nxt;
  logic [31:0]    seqnum_nxt;

  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] s);
    return (s >= SW'(CAPACITY)) ? AW'(s - SW'(CAPACITY)) : AW'(s);
  endfunction

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign evt_good  = (in_event_category < NUM_CATEGORY) && (in_event_action < NUM_ACTION) &&
                     (in_event_outcome < NUM_OUTCOME);
  assign not_full  = (fill_r != FW'(CAPACITY));
  assign read_hit  = (SW'(in_read_index) < SW'(fill_r));
  assign append_slot = not_full ? wrap_slot(SW'(head_r) + SW'(fill_r)) : head_r;
  assign read_slot   = wrap_slot(SW'(head_r) + SW'(in_read_index));

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    seq_nxt    = seq_r;
    drops_nxt  = drops_r;
    ok_nxt     = 1'b0;
    seqnum_nxt = '0;
    mem_ctl    = '0;
    mem_addr   = read_slot;
    mem_wdata.seq           = seq_r + 32'd1;
    mem_wdata.time_ms       = in_event_time_ms;
    mem_wdata.value         = in_value_present ? in_value_bits : 32'd0;
    mem_wdata.tags.category = in_event_category[1:0];
    mem_wdata.tags.action   = in_event_action;
    mem_wdata.tags.outcome  = in_event_outcome[1:0];
    mem_wdata.tags.present  = in_value_present;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
          unique case (in_cmd)
            CMD_APPEND: begin
              if (evt_good) begin
                mem_ctl.wr_en = 1'b1;
                mem_addr      = append_slot;
                seq_nxt       = seq_r + 32'd1;
                ok_nxt        = 1'b1;
                seqnum_nxt    = seq_r + 32'd1;
                if (not_full) begin
                  fill_nxt = fill_r + FW'(1);
                end else begin
                  head_nxt = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
                  if (drops_r != '1) begin
                    drops_nxt = drops_r + 32'd1;
                  end
                end
              end
            end
            CMD_READ: begin
              mem_ctl.rd_en = read_hit;
              ok_nxt        = read_hit;
            end
            CMD_CLEAR: begin
              head_nxt  = '0;
              fill_nxt  = '0;
              seq_nxt   = '0;
              drops_nxt = '0;
              ok_nxt    = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      seq_r       <= '0;
      drops_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      seq_r       <= seq_nxt;
      drops_r     <= drops_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  // command context registered on accept and held for the execute state
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_cmd;
      ok_r     <= ok_nxt;
      seqnum_r <= seqnum_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_ok_r <= ok_r;
      if ((op_r == CMD_READ) && ok_r) begin
        out_seq_number_r <= mem_rdata.seq;
        out_entry_r      <= mem_rdata;
      end else begin
        out_seq_number_r <= seqnum_r;
        out_entry_r      <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_seq_number    = out_seq_number_r;
  assign out_time_ms       = out_entry_r.time_ms;
  assign out_value_bits    = out_entry_r.value;
  assign out_category      = out_entry_r.tags.category;
  assign out_action        = out_entry_r.tags.action;
  assign out_outcome       = out_entry_r.tags.outcome;
  assign out_value_present = out_entry_r.tags.present;
  assign out_entry_count   = 7'(fill_r);
  assign out_drop_count    = drops_r;
  assign out_last_seq      = seq_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CAPACITY))
    else $error("fill exceeds capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < AW'(CAPACITY - 1) || head_r == AW'(CAPACITY - 1))
    else $error("head pointer out of range");

  a_head_moves_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != head_nxt) |-> (!not_full || state_nxt == ST_EXEC))
    else $error("head moved without a transfer");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without execute cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == CMD_CLEAR) |-> (fill_r == '0 && seq_r == '0))
    else $error("clear left entries behind");
`endif

endmodule

`default_nettype wire

[hw/rtl/overwrite_ring_event_log.sv]
// ----------------------------------------------------------------------------
// overwrite_ring_event_log
// Fixed-capacity event log kept in a ring that overwrites its oldest entry.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a rising edge where start is high and busy is low.
//   in_cmd selects append, read (in_read_index counts from the oldest entry)
//   or clear; the event fields only matter for an append.
//   Every command gives exactly one result, shown for one cycle with
//   out_valid high, once the command has passed the execute state and the
//   result registers. The receiver cannot hold results off.
//   busy is high while the execute state lasts, so a new command can
//   be taken once the one before it has left the execute state; the entry
//   memory is read as a command is taken; results come from result registers.
//   Each result also carries the entry count, the saturating drop count and
//   the last sequence number as they stand after the command.
//   Synchronous reset empties the log and zeroes the counters; entry memory is
//   not cleared, and only entries written since are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_event_log #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [63:0] in_event_time_ms,
  input  wire logic [3:0]  in_event_category,
  input  wire logic [3:0]  in_event_action,
  input  wire logic [3:0]  in_event_outcome,
  input  wire logic        in_value_present,
  input  wire logic [31:0] in_value_bits,
  input  wire logic [5:0]  in_read_index,
  output logic             out_valid,
  output logic             out_ok,
  output logic [31:0]      out_seq_number,
  output logic [63:0]      out_time_ms,
  output logic [31:0]      out_value_bits,
  output logic [1:0]       out_category,
  output logic [3:0]       out_action,
  output logic [1:0]       out_outcome,
  output logic             out_value_present,
  output logic [6:0]       out_entry_count,
  output logic [31:0]      out_drop_count,
  output logic [31:0]      out_last_seq
);
  import orlog_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);

  mem_ctl_t       mem_ctl;
  logic [AW-1:0]  mem_addr;
  entry_t         mem_wdata;
  entry_t         mem_rdata;

  orlog_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  orlog_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .FW       (FW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_event_time_ms  (in_event_time_ms),
    .in_event_category (in_event_category),
    .in_event_action   (in_event_action),
    .in_event_outcome  (in_event_outcome),
    .in_value_present  (in_value_present),
    .in_value_bits     (in_value_bits),
    .in_read_index     (in_read_index),
    .mem_ctl           (mem_ctl),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_seq_number    (out_seq_number),
    .out_time_ms       (out_time_ms),
    .out_value_bits    (out_value_bits),
    .out_category      (out_category),
    .out_action        (out_action),
    .out_outcome       (out_outcome),
    .out_value_present (out_value_present),
    .out_entry_count   (out_entry_count),
    .out_drop_count    (out_drop_count),
    .out_last_seq      (out_last_seq)
  );

endmodule

`default_nettype wire
